[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/ntt_pkg.sv]
// ----------------------------------------------------------------------------
// ntt_pkg
// shared constants and codes of the number theoretic transform core
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int unsigned LOG_MAX_DEF = 10;
  localparam int unsigned DW          = 31;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ADDR_W      = 4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_ROOT    = 2'd1;
  localparam logic [1:0] REG_MAXLOG  = 2'd2;
  localparam logic [1:0] REG_LOGLEN  = 2'd3;

  localparam logic [DW-1:0] MODULUS_RST = 31'd998244353;
  localparam logic [DW-1:0] ROOT_RST    = 31'd879587319;
  localparam logic [4:0]    MAXLOG_RST  = 5'd23;
  localparam logic [3:0]    LOGLEN_RST  = 4'd10;

endpackage

[hdl/number_theoretic_transform_core.sv]
// ----------------------------------------------------------------------------
// number_theoretic_transform_core
// in-place radix-2 number theoretic transform on a coefficient memory
// ----------------------------------------------------------------------------
// Commands are taken one at a time. After reset the coefficient memory is
// cleared, and no command is taken while it is cleared. All modular products
// go through one bit-serial multiplier. A run of length n = 2^L costs the root
// squarings (max_log - L products), n-1 twiddle products, a reduce pass of n
// products, a bit-reversal pass, n/2*L butterflies, and for an inverse two
// 31-bit exponentiations plus a scaling pass of n products.
module number_theoretic_transform_core
  import ntt_pkg::*;
#(
  parameter int unsigned LOG_MAX = LOG_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic [DW-1:0]     coefficient_i,
  input  logic              inverse_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DW-1:0]     read_value_o,
  output logic [IDX_W-1:0]  echo_index_o,
  output logic [1:0]        kind_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "assert_macros.svh"

  localparam int unsigned DEPTH = 1 << LOG_MAX;
  localparam int unsigned AW    = LOG_MAX;
  localparam int unsigned CW    = LOG_MAX + 1;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_WR   = 5'd2;
  localparam logic [4:0] S_RD   = 5'd3;
  localparam logic [4:0] S_RESP = 5'd4;
  localparam logic [4:0] S_ROOT = 5'd5;
  localparam logic [4:0] S_SQ   = 5'd6;
  localparam logic [4:0] S_PWS  = 5'd7;
  localparam logic [4:0] S_PWM  = 5'd8;
  localparam logic [4:0] S_TW   = 5'd9;
  localparam logic [4:0] S_RED0 = 5'd10;
  localparam logic [4:0] S_RED1 = 5'd11;
  localparam logic [4:0] S_PRM0 = 5'd12;
  localparam logic [4:0] S_PRM1 = 5'd13;
  localparam logic [4:0] S_PRM2 = 5'd14;
  localparam logic [4:0] S_PRM3 = 5'd15;
  localparam logic [4:0] S_BF0  = 5'd16;
  localparam logic [4:0] S_BF1  = 5'd17;
  localparam logic [4:0] S_BF2  = 5'd18;
  localparam logic [4:0] S_BF3  = 5'd19;
  localparam logic [4:0] S_NINV = 5'd20;
  localparam logic [4:0] S_SC0  = 5'd21;
  localparam logic [4:0] S_SC1  = 5'd22;

  // config registers
  logic [DW-1:0] modulus_q;
  logic [DW-1:0] root_base_q;
  logic [4:0]    max_log_q;
  logic [3:0]    log_length_q;
  logic          cfg_we;

  // control
  logic [4:0]       state_q;
  logic [CW-1:0]    i_q;
  logic [AW-1:0]    t_q;
  logic [LEN_W-1:0] m_q;
  logic [LEN_W-1:0] len_q;
  logic [CNT_W-1:0] ecnt_q;
  logic             mm_pend_q;
  logic             out_valid_q;

  // payload
  logic             inv_q;
  logic             pw_sel_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       op_q;
  logic [DW-1:0]    coef_q;
  logic [DW-1:0]    w_q;
  logic [DW-1:0]    acc_q;
  logic [DW-1:0]    base_q;
  logic [DW-1:0]    cur_q;
  logic [DW-1:0]    e_q;
  logic [DW-1:0]    u_q;
  logic [DW-1:0]    diff_q;
  logic [DW-1:0]    res_val_q;
  logic [DW-1:0]    out_value_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [1:0]       out_kind_q;

  // memories
  logic [DW-1:0] st_mem [DEPTH];
  logic [DW-1:0] tw_mem [DEPTH];
  logic          st_we, st_re, tw_we, tw_re;
  logic [AW-1:0] st_waddr, st_raddr, tw_waddr, tw_raddr;
  logic [DW-1:0] st_wdata, tw_wdata, st_rdata_q, tw_rdata_q;

  // multiplier
  logic          mm_start, mm_done;
  logic [DW-1:0] mm_a, mm_b, mm_res;

  // derived values
  logic [DW-1:0]    unit;
  logic [CW-1:0]    n_len;
  logic [CW-1:0]    n_last;
  logic [AW-1:0]    half_last;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    i_lo;
  logic [AW-1:0]    rev_full;
  logic [AW-1:0]    j_rev;
  logic [AW-1:0]    bmask;
  logic [AW-1:0]    jj;
  logic [AW-1:0]    a0;
  logic [AW-1:0]    a1;
  logic [AW-1:0]    tidx;
  logic [LEN_W-1:0] len_sat;
  logic [DW:0]      pe, bsum, bdif;
  logic [DW-1:0]    sum_v, dif_v;
  logic             swap;
  logic             out_free;
  logic             pw_step;
  logic [DW-1:0]    pw_acc;
  logic             in_acc;

  assign unit      = (modulus_q < DW'(2)) ? '0 : DW'(1);
  assign n_len     = CW'(1) << len_q;
  assign n_last    = n_len - CW'(1);
  assign half_last = AW'((n_len >> 1) - CW'(1));
  assign pos       = AW'(idx_q);
  assign i_lo      = i_q[AW-1:0];
  assign len_sat   = (32'(log_length_q) > LOG_MAX) ? LEN_W'(LOG_MAX) : LEN_W'(log_length_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc    = in_valid_i && in_ready_o;
  assign pw_step   = !e_q[DW-1] || mm_done;
  assign pw_acc    = mm_done ? mm_res : acc_q;

  always_comb begin
    for (int k = 0; k < AW; k++) begin
      rev_full[k] = i_lo[AW-1-k];
    end
  end
  assign j_rev = rev_full >> (LEN_W'(AW) - len_q);
  assign swap  = i_lo < j_rev;

  assign bmask = (AW'(1) << m_q) - AW'(1);
  assign jj    = t_q & bmask;
  assign a0    = ((t_q >> m_q) << (m_q + LEN_W'(1))) | jj;
  assign a1    = a0 | (AW'(1) << m_q);
  assign tidx  = jj << (len_q - LEN_W'(1) - m_q);

  always_comb begin
    pe   = {1'b0, modulus_q};
    bsum = {1'b0, u_q} + {1'b0, mm_res};
    if (bsum >= pe) begin
      bsum = bsum - pe;
    end
    bdif = {1'b0, u_q} + pe - {1'b0, mm_res};
    if (bdif >= pe) begin
      bdif = bdif - pe;
    end
    sum_v = (modulus_q < DW'(2)) ? '0 : bsum[DW-1:0];
    dif_v = (modulus_q < DW'(2)) ? '0 : bdif[DW-1:0];
  end

  ntt_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .p_i     (modulus_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  // memory and multiplier control
  always_comb begin
    st_we    = 1'b0;
    st_re    = 1'b0;
    tw_we    = 1'b0;
    tw_re    = 1'b0;
    st_waddr = i_lo;
    st_raddr = i_lo;
    tw_waddr = i_lo;
    tw_raddr = tidx;
    st_wdata = mm_res;
    tw_wdata = mm_res;
    mm_start = 1'b0;
    mm_a     = st_rdata_q;
    mm_b     = DW'(1);
    case (state_q)
      S_CLR: begin
        st_we    = 1'b1;
        st_wdata = '0;
      end
      S_IDLE: begin
        if (in_valid_i && (opcode_i == OP_READ)) begin
          st_re    = 1'b1;
          st_raddr = AW'(index_i);
        end
      end
      S_WR: begin
        mm_start = !mm_pend_q;
        mm_a     = coef_q;
        st_we    = mm_done;
        st_waddr = pos;
      end
      S_ROOT: begin
        mm_start = !mm_pend_q && !(len_q > max_log_q);
        mm_a     = root_base_q;
      end
      S_SQ: begin
        mm_start = !mm_pend_q && (ecnt_q != '0);
        mm_a     = w_q;
        mm_b     = w_q;
      end
      S_PWS: begin
        mm_start = !mm_pend_q;
        mm_a     = acc_q;
        mm_b     = acc_q;
      end
      S_PWM: begin
        mm_start = !mm_pend_q && e_q[DW-1];
        mm_a     = acc_q;
        mm_b     = base_q;
      end
      S_TW: begin
        if (i_q == '0) begin
          tw_we    = 1'b1;
          tw_wdata = unit;
        end else begin
          mm_start = !mm_pend_q;
          mm_a     = cur_q;
          mm_b     = w_q;
          tw_we    = mm_done;
        end
      end
      S_RED0: begin
        st_re = 1'b1;
      end
      S_RED1: begin
        mm_start = !mm_pend_q;
        st_we    = mm_done;
      end
      S_PRM0: begin
        st_re = swap;
      end
      S_PRM1: begin
        st_re    = 1'b1;
        st_raddr = j_rev;
      end
      S_PRM2: begin
        st_we    = 1'b1;
        st_wdata = st_rdata_q;
      end
      S_PRM3: begin
        st_we    = 1'b1;
        st_waddr = j_rev;
        st_wdata = u_q;
      end
      S_BF0: begin
        st_re    = 1'b1;
        st_raddr = a0;
        tw_re    = 1'b1;
      end
      S_BF1: begin
        st_re    = 1'b1;
        st_raddr = a1;
      end
      S_BF2: begin
        mm_start = !mm_pend_q;
        mm_b     = tw_rdata_q;
        st_we    = mm_done;
        st_waddr = a0;
        st_wdata = sum_v;
      end
      S_BF3: begin
        st_we    = 1'b1;
        st_waddr = a1;
        st_wdata = diff_q;
      end
      S_NINV: begin
        mm_start = !mm_pend_q;
        mm_a     = DW'(n_len);
      end
      S_SC0: begin
        st_re = 1'b1;
      end
      S_SC1: begin
        mm_start = !mm_pend_q;
        mm_b     = w_q;
        st_we    = mm_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= st_mem[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tw_we) begin
      tw_mem[tw_waddr] <= tw_wdata;
    end
    if (tw_re) begin
      tw_rdata_q <= tw_mem[tw_raddr];
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      i_q       <= '0;
      t_q       <= '0;
      m_q       <= '0;
      len_q     <= '0;
      ecnt_q    <= '0;
      mm_pend_q <= 1'b0;
    end else begin
      if (mm_done) begin
        mm_pend_q <= 1'b0;
      end else if (mm_start) begin
        mm_pend_q <= 1'b1;
      end
      case (state_q)
        S_CLR: begin
          if (i_lo == '1) begin
            i_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            case (opcode_i)
              OP_WRITE: state_q <= S_WR;
              OP_READ:  state_q <= S_RD;
              OP_RUN: begin
                len_q   <= len_sat;
                state_q <= S_ROOT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_WR: begin
          if (mm_done) begin
            state_q <= S_RESP;
          end
        end
        S_RD: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (len_q > max_log_q) begin
            ecnt_q  <= '0;
            state_q <= S_SQ;
          end else if (mm_done) begin
            ecnt_q  <= max_log_q - len_q;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (ecnt_q == '0) begin
            i_q <= '0;
            if (inv_q) begin
              ecnt_q  <= CNT_W'(DW);
              state_q <= S_PWS;
            end else begin
              state_q <= S_TW;
            end
          end else if (mm_done) begin
            ecnt_q <= ecnt_q - CNT_W'(1);
          end
        end
        S_PWS: begin
          if (mm_done) begin
            state_q <= S_PWM;
          end
        end
        S_PWM: begin
          if (pw_step) begin
            ecnt_q <= ecnt_q - CNT_W'(1);
            if (ecnt_q == CNT_W'(1)) begin
              i_q     <= '0;
              state_q <= pw_sel_q ? S_SC0 : S_TW;
            end else begin
              state_q <= S_PWS;
            end
          end
        end
        S_TW: begin
          if (i_q == '0) begin
            if (n_len == CW'(1)) begin
              state_q <= S_RED0;
            end else begin
              i_q <= CW'(1);
            end
          end else if (mm_done) begin
            if (i_q == n_last) begin
              i_q     <= '0;
              state_q <= S_RED0;
            end else begin
              i_q <= i_q + CW'(1);
            end
          end
        end
        S_RED0: begin
          state_q <= S_RED1;
        end
        S_RED1: begin
          if (mm_done) begin
            if (i_q == n_last) begin
              i_q     <= '0;
              state_q <= S_PRM0;
            end else begin
              i_q     <= i_q + CW'(1);
              state_q <= S_RED0;
            end
          end
        end
        S_PRM0, S_PRM3: begin
          if ((state_q == S_PRM0) && swap) begin
            state_q <= S_PRM1;
          end else if (i_q == n_last) begin
            i_q <= '0;
            t_q <= '0;
            m_q <= '0;
            if (len_q == '0) begin
              state_q <= inv_q ? S_NINV : S_RESP;
            end else begin
              state_q <= S_BF0;
            end
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_PRM0;
          end
        end
        S_PRM1: begin
          state_q <= S_PRM2;
        end
        S_PRM2: begin
          state_q <= S_PRM3;
        end
        S_BF0: begin
          state_q <= S_BF1;
        end
        S_BF1: begin
          state_q <= S_BF2;
        end
        S_BF2: begin
          if (mm_done) begin
            state_q <= S_BF3;
          end
        end
        S_BF3: begin
          state_q <= S_BF0;
          if (t_q == half_last) begin
            t_q <= '0;
            if (m_q == len_q - LEN_W'(1)) begin
              state_q <= inv_q ? S_NINV : S_RESP;
            end else begin
              m_q <= m_q + LEN_W'(1);
            end
          end else begin
            t_q <= t_q + AW'(1);
          end
        end
        S_NINV: begin
          if (mm_done) begin
            ecnt_q  <= CNT_W'(DW);
            state_q <= S_PWS;
          end
        end
        S_SC0: begin
          state_q <= S_SC1;
        end
        S_SC1: begin
          if (mm_done) begin
            if (i_q == n_last) begin
              state_q <= S_RESP;
            end else begin
              i_q     <= i_q + CW'(1);
              state_q <= S_SC0;
            end
          end
        end
        default: state_q <= S_CLR;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q      <= opcode_i;
        idx_q     <= index_i;
        coef_q    <= coefficient_i;
        inv_q     <= inverse_i;
        res_val_q <= '0;
      end
      S_RD: begin
        res_val_q <= st_rdata_q;
      end
      S_ROOT: begin
        if (len_q > max_log_q) begin
          w_q <= unit;
        end else if (mm_done) begin
          w_q <= mm_res;
        end
      end
      S_SQ: begin
        if (ecnt_q == '0) begin
          acc_q    <= unit;
          base_q   <= w_q;
          e_q      <= modulus_q - DW'(2);
          pw_sel_q <= 1'b0;
        end else if (mm_done) begin
          w_q <= mm_res;
        end
      end
      S_PWS: begin
        if (mm_done) begin
          acc_q <= mm_res;
        end
      end
      S_PWM: begin
        if (pw_step) begin
          acc_q <= pw_acc;
          e_q   <= {e_q[DW-2:0], 1'b0};
          if (ecnt_q == CNT_W'(1)) begin
            w_q <= pw_acc;
          end
        end
      end
      S_TW: begin
        if (i_q == '0) begin
          cur_q <= unit;
        end else if (mm_done) begin
          cur_q <= mm_res;
        end
      end
      S_PRM1, S_BF1: begin
        u_q <= st_rdata_q;
      end
      S_BF2: begin
        if (mm_done) begin
          diff_q <= dif_v;
        end
      end
      S_NINV: begin
        if (mm_done) begin
          base_q   <= mm_res;
          acc_q    <= unit;
          e_q      <= modulus_q - DW'(2);
          pw_sel_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_RESP) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_RESP) && out_free) begin
      out_value_q <= res_val_q;
      out_idx_q   <= idx_q;
      out_kind_q  <= op_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign echo_index_o = out_idx_q;
  assign kind_o       = out_kind_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= MODULUS_RST;
      root_base_q  <= ROOT_RST;
      max_log_q    <= MAXLOG_RST;
      log_length_q <= LOGLEN_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MODULUS: modulus_q    <= pwdata[DW-1:0];
        REG_ROOT:    root_base_q  <= pwdata[DW-1:0];
        REG_MAXLOG:  max_log_q    <= pwdata[4:0];
        REG_LOGLEN:  log_length_q <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODULUS: prdata = 32'(modulus_q);
      REG_ROOT:    prdata = 32'(root_base_q);
      REG_MAXLOG:  prdata = 32'(max_log_q);
      REG_LOGLEN:  prdata = 32'(log_length_q);
      default:     prdata = '0;
    endcase
  end

  `ASSERT_IMPL(a_mm_done_awaited, mm_done, mm_pend_q)
  `ASSERT_IMPL(a_swap_pair_read, state_q == S_PRM2, $past(state_q) == S_PRM1)
  `ASSERT_IMPL(a_no_cmd_while_busy, in_acc, !mm_pend_q && !out_valid_q || in_ready_o)
  `ASSERT_NEXT(a_bf_upper_write, (state_q == S_BF2) && mm_done, st_we && (st_waddr == a1))

endmodule

[hdl/ntt_modmul.sv]
// ----------------------------------------------------------------------------
// ntt_modmul
// bit-serial modular multiplier, one multiplier bit per cycle, b below p
// ----------------------------------------------------------------------------
module ntt_modmul
  import ntt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  input  logic [DW-1:0] p_i,
  output logic          done_o,
  output logic [DW-1:0] res_o
);

`include "assert_macros.svh"

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    a_q;
  logic [DW-1:0]    b_q;
  logic [DW-1:0]    r_q;
  logic [DW-1:0]    r_d;
  logic [DW:0]      pe;
  logic [DW:0]      t1;
  logic [DW:0]      t2;

  always_comb begin
    pe = {1'b0, p_i};
    t1 = {r_q, 1'b0};
    if (t1 >= pe) begin
      t1 = t1 - pe;
    end
    t2 = t1 + (a_q[DW-1] ? {1'b0, b_q} : '0);
    if (t2 >= pe) begin
      t2 = t2 - pe;
    end
    r_d = t2[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      a_q <= {a_q[DW-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = (p_i < DW'(2)) ? '0 : r_q;

  `ASSERT_IMPL(a_start_idle, start_i, !busy_q)
  `ASSERT_NEXT(a_start_busy, start_i, busy_q)
  `ASSERT_NEXT(a_last_step_done, busy_q && (cnt_q == CNT_W'(1)) && !start_i, done_o)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for number_theoretic_transform_core. A queue of commands
// is driven over valid/ready while an in-bench model of the coefficient store
// tracks writes, forward and inverse transforms and reads. Each result beat is
// checked against the oldest predicted beat. Field settings change over the
// APB port between phases, and both sides idle at varying rates.
// ----------------------------------------------------------------------------
module tb;
  import ntt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned DEPTH = 1 << LOG_MAX_DEF;
  localparam int unsigned IDLE_LIMIT = 1200000;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    coef;
    logic             inv;
  } cmd_t;

  typedef struct packed {
    logic [DW-1:0]    value;
    logic [IDX_W-1:0] idx;
    logic [1:0]       kind;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        opcode_i = '0;
  logic [IDX_W-1:0]  index_i = '0;
  logic [DW-1:0]     coefficient_i = '0;
  logic              inverse_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DW-1:0]     read_value_o;
  logic [IDX_W-1:0]  echo_index_o;
  logic [1:0]        kind_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  number_theoretic_transform_core dut (.*);

  always #1 clk_i = ~clk_i;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned n_cmds = 0, n_runs = 0, n_reads = 0, n_answers = 0;

  // field settings and store model
  logic [DW-1:0] p_mod;
  logic [DW-1:0] p_root;
  logic [4:0]    p_maxlog;
  logic [3:0]    p_loglen;
  logic [DW-1:0] coef_store[DEPTH];
  logic [DW-1:0] twiddles[DEPTH];

  function automatic logic [DW-1:0] mod_reduce(longint unsigned v, logic [DW-1:0] p);
    if (p < 2) return '0;
    return DW'(v % longint'(p));
  endfunction

  function automatic logic [DW-1:0] mod_mult(logic [DW-1:0] a, logic [DW-1:0] b,
                                             logic [DW-1:0] p);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return mod_reduce(prod, p);
  endfunction

  function automatic logic [DW-1:0] mod_power(logic [DW-1:0] b0, longint unsigned e,
                                              logic [DW-1:0] p);
    logic [DW-1:0] r, b;
    r = mod_reduce(1, p);
    b = mod_reduce(b0, p);
    while (e != 0) begin
      if (e[0]) r = mod_mult(r, b, p);
      b = mod_mult(b, b, p);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic int unsigned reverse_bits(int unsigned i, int unsigned bits);
    int unsigned r;
    r = 0;
    for (int k = 0; k < bits; k++) begin
      r = (r << 1) | (i & 1);
      i = i >> 1;
    end
    return r;
  endfunction

  task automatic transform_store(bit inv);
    int unsigned len_log, n, j, k;
    logic [DW-1:0] w, u, v, t, ninv;
    longint unsigned e;
    len_log = (p_loglen > LOG_MAX_DEF) ? LOG_MAX_DEF : p_loglen;
    n = 1 << len_log;
    e = (p_mod >= 2) ? longint'(p_mod) - 2 : 0;
    if (len_log > p_maxlog) begin
      w = mod_reduce(1, p_mod);
    end else begin
      w = mod_reduce(p_root, p_mod);
      for (int i = 0; i < p_maxlog - len_log; i++) w = mod_mult(w, w, p_mod);
    end
    if (inv) w = mod_power(w, e, p_mod);
    twiddles[0] = mod_reduce(1, p_mod);
    for (int i = 1; i < n; i++) twiddles[i] = mod_mult(twiddles[i-1], w, p_mod);
    for (int i = 0; i < n; i++) coef_store[i] = mod_reduce(coef_store[i], p_mod);
    for (int i = 0; i < n; i++) begin
      j = reverse_bits(i, len_log);
      if (i < j) begin
        t = coef_store[i];
        coef_store[i] = coef_store[j];
        coef_store[j] = t;
      end
    end
    k = len_log;
    for (int s = 1; s < n; s = s << 1) begin
      k--;
      for (int i = 0; i < n; i += 2 * s) begin
        for (int jj = 0; jj < s; jj++) begin
          u = coef_store[i+jj];
          v = mod_mult(coef_store[i+jj+s], twiddles[(jj << k) & (DEPTH - 1)], p_mod);
          coef_store[i+jj]   = mod_reduce(longint'(u) + longint'(v), p_mod);
          coef_store[i+jj+s] = mod_reduce(longint'(u) + longint'(p_mod) - longint'(v), p_mod);
        end
      end
    end
    if (inv) begin
      ninv = mod_power(mod_reduce(n, p_mod), e, p_mod);
      for (int i = 0; i < n; i++) coef_store[i] = mod_mult(coef_store[i], ninv, p_mod);
    end
  endtask

  task automatic predict_answer(cmd_t c);
    answer_t a;
    a.value = '0;
    a.idx   = c.idx;
    a.kind  = c.op;
    case (c.op)
      OP_WRITE: coef_store[c.idx] = mod_reduce(c.coef, p_mod);
      OP_RUN: begin
        transform_store(c.inv);
        n_runs++;
      end
      OP_READ: begin
        a.value = coef_store[c.idx];
        n_reads++;
      end
      default: return;
    endcase
    n_cmds++;
    expected_answers.push_back(a);
  endtask

  // command driver and input beat capture
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        predict_answer('{opcode_i, index_i, coefficient_i, inverse_i});
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_valid_i    <= 1'b1;
          opcode_i      <= c.op;
          index_i       <= c.idx;
          coefficient_i <= c.coef;
          inverse_i     <= c.inv;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver with long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt    <= 600;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 1) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (hold_cnt == 1) hold_cnt <= hold_cnt - 1;
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_answers++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: value %0d index %0d kind %0d",
                   read_value_o, echo_index_o, kind_o);
      end else begin
        e = expected_answers.pop_front();
        if (e.value !== read_value_o || e.idx !== echo_index_o || e.kind !== kind_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %0d index %0d kind %0d, got %0d %0d %0d",
                     e.value, e.idx, e.kind, read_value_o, echo_index_o, kind_o);
        end
      end
    end
  end

  // watchdog
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_MODULUS: p_mod    = value[DW-1:0];
      REG_ROOT:    p_root   = value[DW-1:0];
      REG_MAXLOG:  p_maxlog = value[4:0];
      default:     p_loglen = value[3:0];
    endcase
  endtask

  task automatic configure(logic [31:0] m, logic [31:0] r, logic [31:0] ml, logic [31:0] ll);
    apb_write(REG_MODULUS, m);
    apb_write(REG_ROOT, r);
    apb_write(REG_MAXLOG, ml);
    apb_write(REG_LOGLEN, ll);
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (pending_cmds.size() > 0 || in_valid_i || expected_answers.size() > 0);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic push_cmd(logic [1:0] op, int unsigned idx, logic [DW-1:0] coef, bit inv);
    pending_cmds.push_back('{op, IDX_W'(idx), coef, inv});
  endtask

  function automatic logic [DW-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return DW'($urandom_range(20));
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned idle_s, int unsigned idle_r);
    int unsigned made, n, ll;
    send_idle_pct  = idle_s;
    recv_stall_pct = idle_r;
    made = 0;
    ll = (p_loglen > LOG_MAX_DEF) ? LOG_MAX_DEF : p_loglen;
    n = 1 << ll;
    while (made < count) begin
      if ($urandom_range(99) < 75) begin
        for (int i = 0; i < n; i++) push_cmd(OP_WRITE, i, rand_coef(), 1'b0);
        push_cmd(OP_RUN, $urandom, rand_coef(), $urandom_range(1));
        if ($urandom_range(3) == 0)
          push_cmd(OP_RUN, $urandom, rand_coef(), $urandom_range(1));
        for (int i = 0; i < n; i++) push_cmd(OP_READ, i, rand_coef(), $urandom_range(1));
        made += 2 * n + 1;
      end else begin
        for (int i = 0; i < 6; i++) begin
          case ($urandom_range(9))
            0:       push_cmd(OP_NONE, $urandom, rand_coef(), $urandom_range(1));
            1:       push_cmd(OP_RUN, $urandom, rand_coef(), $urandom_range(1));
            2, 3, 4: push_cmd(OP_READ, $urandom, rand_coef(), $urandom_range(1));
            default: push_cmd(OP_WRITE, $urandom_range(1) ? $urandom : $urandom_range(n - 1),
                              rand_coef(), $urandom_range(1));
          endcase
          made++;
        end
      end
    end
    drain();
  endtask

  initial begin
    p_mod    = MODULUS_RST;
    p_root   = ROOT_RST;
    p_maxlog = MAXLOG_RST;
    p_loglen = LOGLEN_RST;
    for (int i = 0; i < DEPTH; i++) begin
      coef_store[i] = '0;
      twiddles[i]   = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);

    // reset store, field extremes, ignored opcode, one full-length run
    push_cmd(OP_READ, 0, '0, 1'b0);
    push_cmd(OP_READ, 1023, '1, 1'b1);
    push_cmd(OP_WRITE, 0, '1, 1'b0);
    push_cmd(OP_WRITE, 1023, 31'd998244352, 1'b1);
    push_cmd(OP_WRITE, 1, '0, 1'b0);
    push_cmd(OP_NONE, 5, '1, 1'b1);
    push_cmd(OP_READ, 0, '0, 1'b0);
    drain();
    apb_write(REG_LOGLEN, 32'hffff_ffff);
    push_cmd(OP_RUN, 1023, '0, 1'b0);
    push_cmd(OP_READ, 1023, '0, 1'b0);
    push_cmd(OP_READ, 512, '0, 1'b0);
    drain();

    // length one, stale entries under a smaller modulus, degenerate modulus
    apb_write(REG_LOGLEN, 0);
    push_cmd(OP_WRITE, 0, '1, 1'b0);
    push_cmd(OP_RUN, 7, '0, 1'b0);
    push_cmd(OP_READ, 0, '0, 1'b0);
    drain();
    configure(17, 3, 4, 0);
    push_cmd(OP_RUN, 0, '0, 1'b1);
    push_cmd(OP_READ, 0, '0, 1'b0);
    push_cmd(OP_READ, 2, '0, 1'b0);
    drain();
    apb_write(REG_LOGLEN, 2);
    push_cmd(OP_RUN, 0, '0, 1'b1);
    for (int i = 0; i < 4; i++) push_cmd(OP_READ, i, '0, 1'b0);
    drain();
    configure(1, 1, 0, 2);
    push_cmd(OP_WRITE, 3, '1, 1'b0);
    push_cmd(OP_RUN, 0, '0, 1'b1);
    push_cmd(OP_READ, 3, '0, 1'b0);
    drain();

    configure(998244353, 879587319, 23, 3);
    hold_req = 1'b1;
    random_phase(140, 0, 0);
    hold_req = 1'b0;
    configure(17, 3, 4, 5);
    random_phase(120, 81, 0);
    configure(2147483647, 2147483646, 1, 1);
    random_phase(110, 0, 81);
    configure(97, 2147483646, 31, 4);
    random_phase(130, 23, 23);
    configure(15, 2, 0, 3);
    random_phase(120, 0, 0);
    configure(3, 2, 1, 2);
    random_phase(110, 23, 23);

    repeat (200) @(posedge clk_i);
    $display("covered %0d commands: %0d transforms, %0d reads, %0d result beats",
             n_cmds, n_runs, n_reads, n_answers);
    $display("field settings from modulus 1 to 2^31-1, lengths 1 to 1024, all idle mixes");
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, expected_answers.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
